// ----- hw/rtl/mbs_pkg.sv -----
package mbs_pkg;

    // Run phase, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_WAIT_MODE = 5'b00010,
        PH_WAIT_FB   = 5'b00100,
        PH_READY     = 5'b01000,
        PH_FAILED    = 5'b10000
    } t_phase;

    // Run state codes as they appear on the result.
    localparam logic [2:0] RUN_IDLE      = 3'd0;
    localparam logic [2:0] RUN_WAIT_MODE = 3'd1;
    localparam logic [2:0] RUN_WAIT_FB   = 3'd2;
    localparam logic [2:0] RUN_READY     = 3'd3;
    localparam logic [2:0] RUN_FAILED    = 3'd4;

    // Command codes of an input item.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_FEEDBACK = 2'd1;
    localparam logic [1:0] CMD_TARGET   = 2'd2;
    localparam logic [1:0] CMD_START    = 2'd3;

    // Error codes in this range latch a fault.
    localparam logic [7:0] FAULT_ERR_LO = 8'h08;
    localparam logic [7:0] FAULT_ERR_HI = 8'h0E;

    // Configuration register map.
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_AUTO_MODE_DELAY = 3'd0;
    localparam logic [2:0] REG_RETRY_DELAY     = 3'd1;
    localparam logic [2:0] REG_MAX_ATTEMPTS    = 3'd2;
    localparam logic [2:0] REG_RESEND_PERIOD   = 3'd3;
    localparam logic [2:0] REG_STALE_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_DEFAULT_SPEED   = 3'd5;
    localparam logic [2:0] REG_OWN_MOTOR_ID    = 3'd6;

    localparam logic [15:0] AUTO_MODE_DELAY_RST = 16'd100;
    localparam logic [15:0] RETRY_DELAY_RST     = 16'd500;
    localparam logic [3:0]  MAX_ATTEMPTS_RST    = 4'd3;
    localparam logic [15:0] RESEND_PERIOD_RST   = 16'd10;
    localparam logic [15:0] STALE_TIMEOUT_RST   = 16'd500;
    localparam logic [30:0] DEFAULT_SPEED_RST   = 31'd65536;
    localparam logic [7:0]  OWN_MOTOR_ID_RST    = 8'd1;

    typedef struct packed {
        logic [15:0] auto_mode_delay;
        logic [15:0] retry_delay;
        logic [3:0]  max_attempts;
        logic [15:0] resend_period;
        logic [15:0] stale_timeout;
        logic [30:0] default_speed;
        logic [7:0]  own_motor_id;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_ms;
        logic [7:0]         fb_motor_id;
        logic signed [31:0] fb_position;
        logic [7:0]         fb_error_code;
        logic signed [31:0] target_position;
        logic signed [31:0] target_speed;
        logic               mode_entry_ok;
        logic               send_ok;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic               feedback_pending;
        logic               err_pending;
        logic [7:0]         fault_value;
        logic signed [31:0] last_fb_position;
        logic               seen_feedback;
        logic               drive_enabled;
        logic               fault_latch;
        logic               hold_locked;
        logic signed [31:0] goal_position;
        logic [30:0]        goal_speed;
        logic [31:0]        last_feedback_time;
        logic [31:0]        last_send_time;
        logic [31:0]        mode_wait_start;
        logic [15:0]        mode_wait_length;
        logic [3:0]         attempt_count;
    } t_state;

    typedef struct packed {
        logic               req_disable;
        logic               req_enter_mode;
        logic               req_send_target;
        logic signed [31:0] cmd_position;
        logic [30:0]        cmd_speed;
        logic [2:0]         run_state;
        logic               ready_res;
        logic               accepted;
        logic               has_feedback;
        logic signed [31:0] feedback_position;
        logic [7:0]         fault_err;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:      code = RUN_IDLE;
            PH_WAIT_MODE: code = RUN_WAIT_MODE;
            PH_WAIT_FB:   code = RUN_WAIT_FB;
            PH_READY:     code = RUN_READY;
            PH_FAILED:    code = RUN_FAILED;
            default:      code = RUN_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/mbs_cfg.sv -----
module mbs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mbs_pkg::t_cfg               o_cfg
);

    logic [15:0] r_auto_mode_delay;
    logic [15:0] r_retry_delay;
    logic [3:0]  r_max_attempts;
    logic [15:0] r_resend_period;
    logic [15:0] r_stale_timeout;
    logic [30:0] r_default_speed;
    logic [7:0]  r_own_motor_id;

    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[mbs_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode_delay <= mbs_pkg::AUTO_MODE_DELAY_RST;
            r_retry_delay     <= mbs_pkg::RETRY_DELAY_RST;
            r_max_attempts    <= mbs_pkg::MAX_ATTEMPTS_RST;
            r_resend_period   <= mbs_pkg::RESEND_PERIOD_RST;
            r_stale_timeout   <= mbs_pkg::STALE_TIMEOUT_RST;
            r_default_speed   <= mbs_pkg::DEFAULT_SPEED_RST;
            r_own_motor_id    <= mbs_pkg::OWN_MOTOR_ID_RST;
        end else if (wr_en) begin
            case (reg_idx)
                mbs_pkg::REG_AUTO_MODE_DELAY: r_auto_mode_delay <= pwdata[15:0];
                mbs_pkg::REG_RETRY_DELAY:     r_retry_delay     <= pwdata[15:0];
                mbs_pkg::REG_MAX_ATTEMPTS:    r_max_attempts    <= pwdata[3:0];
                mbs_pkg::REG_RESEND_PERIOD:   r_resend_period   <= pwdata[15:0];
                mbs_pkg::REG_STALE_TIMEOUT:   r_stale_timeout   <= pwdata[15:0];
                mbs_pkg::REG_DEFAULT_SPEED:   r_default_speed   <= pwdata[30:0];
                mbs_pkg::REG_OWN_MOTOR_ID:    r_own_motor_id    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mbs_pkg::REG_AUTO_MODE_DELAY: prdata = {16'd0, r_auto_mode_delay};
            mbs_pkg::REG_RETRY_DELAY:     prdata = {16'd0, r_retry_delay};
            mbs_pkg::REG_MAX_ATTEMPTS:    prdata = {28'd0, r_max_attempts};
            mbs_pkg::REG_RESEND_PERIOD:   prdata = {16'd0, r_resend_period};
            mbs_pkg::REG_STALE_TIMEOUT:   prdata = {16'd0, r_stale_timeout};
            mbs_pkg::REG_DEFAULT_SPEED:   prdata = {1'b0, r_default_speed};
            mbs_pkg::REG_OWN_MOTOR_ID:    prdata = {24'd0, r_own_motor_id};
            default:                      prdata = 32'd0;
        endcase
    end

    assign o_cfg.auto_mode_delay = r_auto_mode_delay;
    assign o_cfg.retry_delay     = r_retry_delay;
    assign o_cfg.max_attempts    = r_max_attempts;
    assign o_cfg.resend_period   = r_resend_period;
    assign o_cfg.stale_timeout   = r_stale_timeout;
    assign o_cfg.default_speed   = r_default_speed;
    assign o_cfg.own_motor_id    = r_own_motor_id;

endmodule

// ----- hw/rtl/mbs_step.sv -----
module mbs_step (
    input  mbs_pkg::t_state  i_state,
    input  mbs_pkg::t_cfg    i_cfg,
    input  mbs_pkg::t_item   i_item,
    output mbs_pkg::t_state  o_state,
    output mbs_pkg::t_result o_result
);

    mbs_pkg::t_state n_state;
    logic            rq_dis;
    logic            rq_mode;
    logic            rq_send;
    logic            acc;
    logic            ready_pre;
    logic            updated;
    logic [31:0]     now;

    function automatic logic is_ready(input mbs_pkg::t_state st, input logic [15:0] stale,
                                      input logic [31:0] t);
        logic [31:0] age;
        age = t - st.last_feedback_time;
        return (st.phase == mbs_pkg::PH_READY) && st.drive_enabled && !st.fault_latch &&
               st.hold_locked && st.seen_feedback && (age <= {16'd0, stale});
    endfunction

    assign now       = i_item.now_ms;
    assign ready_pre = is_ready(i_state, i_cfg.stale_timeout, now);

    always_comb begin
        n_state = i_state;
        rq_dis  = 1'b0;
        rq_mode = 1'b0;
        rq_send = 1'b0;
        acc     = 1'b0;
        updated = i_state.feedback_pending;
        case (i_item.cmd)
            mbs_pkg::CMD_START: begin
                n_state.phase              = mbs_pkg::PH_WAIT_MODE;
                n_state.feedback_pending   = 1'b0;
                n_state.err_pending        = 1'b0;
                n_state.fault_value        = 8'd0;
                n_state.last_fb_position   = 32'sd0;
                n_state.seen_feedback      = 1'b0;
                n_state.drive_enabled      = 1'b0;
                n_state.fault_latch        = 1'b0;
                n_state.hold_locked        = 1'b0;
                n_state.goal_position      = 32'sd0;
                n_state.goal_speed         = i_cfg.default_speed;
                n_state.last_feedback_time = now;
                n_state.last_send_time     = now;
                n_state.mode_wait_start    = now;
                n_state.mode_wait_length   = i_cfg.auto_mode_delay;
                n_state.attempt_count      = 4'd0;
                rq_dis                     = 1'b1;
            end
            mbs_pkg::CMD_FEEDBACK: begin
                if (i_item.fb_motor_id == i_cfg.own_motor_id) begin
                    n_state.last_fb_position = i_item.fb_position;
                    n_state.feedback_pending = 1'b1;
                    if (i_item.fb_error_code >= mbs_pkg::FAULT_ERR_LO &&
                        i_item.fb_error_code <= mbs_pkg::FAULT_ERR_HI) begin
                        n_state.fault_value = i_item.fb_error_code;
                        n_state.err_pending = 1'b1;
                    end
                end
            end
            mbs_pkg::CMD_TARGET: begin
                if (ready_pre && !i_item.target_speed[31]) begin
                    n_state.goal_position = i_item.target_position;
                    n_state.goal_speed    = i_item.target_speed[30:0];
                    acc                   = 1'b1;
                end
            end
            default: begin
                // Process tick. Steps below see the effects of the steps before them.
                n_state.feedback_pending = 1'b0;
                if (i_state.err_pending) begin
                    n_state.err_pending   = 1'b0;
                    n_state.fault_latch   = 1'b1;
                    n_state.drive_enabled = 1'b0;
                    n_state.hold_locked   = 1'b0;
                    n_state.phase         = mbs_pkg::PH_FAILED;
                    rq_dis                = 1'b1;
                end else begin
                    if (i_state.phase == mbs_pkg::PH_WAIT_MODE &&
                        (now - i_state.mode_wait_start) >= {16'd0, i_state.mode_wait_length}) begin
                        n_state.attempt_count = i_state.attempt_count + 4'd1;
                        rq_mode = 1'b1;
                        if (i_item.mode_entry_ok) begin
                            n_state.drive_enabled      = 1'b1;
                            n_state.phase              = mbs_pkg::PH_WAIT_FB;
                            n_state.last_feedback_time = now;
                            n_state.last_send_time     = now;
                        end else if (n_state.attempt_count < i_cfg.max_attempts) begin
                            n_state.mode_wait_start  = now;
                            n_state.mode_wait_length = i_cfg.retry_delay;
                        end else begin
                            n_state.drive_enabled = 1'b0;
                            n_state.hold_locked   = 1'b0;
                            n_state.phase         = mbs_pkg::PH_FAILED;
                        end
                    end
                    if (updated) begin
                        n_state.seen_feedback      = 1'b1;
                        n_state.last_feedback_time = now;
                        if (n_state.phase == mbs_pkg::PH_WAIT_FB && n_state.drive_enabled &&
                            !n_state.fault_latch) begin
                            n_state.goal_position = n_state.last_fb_position;
                            n_state.goal_speed    = i_cfg.default_speed;
                            rq_send               = 1'b1;
                            if (i_item.send_ok) begin
                                n_state.hold_locked    = 1'b1;
                                n_state.last_send_time = now;
                                n_state.phase          = mbs_pkg::PH_READY;
                            end else begin
                                n_state.hold_locked   = 1'b0;
                                n_state.drive_enabled = 1'b0;
                                n_state.phase         = mbs_pkg::PH_FAILED;
                                rq_dis                = 1'b1;
                            end
                        end
                    end
                    if (n_state.phase == mbs_pkg::PH_READY && n_state.drive_enabled &&
                        !n_state.fault_latch && n_state.hold_locked &&
                        (now - n_state.last_send_time) >= {16'd0, i_cfg.resend_period}) begin
                        n_state.last_send_time = now;
                        rq_send                = 1'b1;
                    end
                end
            end
        endcase
    end

    assign o_state = n_state;

    assign o_result.req_disable       = rq_dis;
    assign o_result.req_enter_mode    = rq_mode;
    assign o_result.req_send_target   = rq_send;
    assign o_result.cmd_position      = n_state.goal_position;
    assign o_result.cmd_speed         = n_state.goal_speed;
    assign o_result.run_state         = mbs_pkg::phase_code(n_state.phase);
    assign o_result.ready_res         = is_ready(n_state, i_cfg.stale_timeout, now);
    assign o_result.accepted          = acc;
    assign o_result.has_feedback      = n_state.seen_feedback;
    assign o_result.feedback_position = n_state.last_fb_position;
    assign o_result.fault_err         = n_state.fault_value;

endmodule

// ----- hw/rtl/motor_bringup_supervisor.sv -----
// Path: an accepted input beat waits in the input register, then the state update
// writes its result into the result register; a stall holds it in the input register.
// Throughput: one item per cycle while the output is not stalled; the combinational state update sets it.
// Reset (i_rst_n low, synchronous): both pipeline stages empty, supervision state
// back to idle with default hold speed, configuration registers to their defaults.
module motor_bringup_supervisor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [31:0]                 i_now_ms,
    input  logic [7:0]                  i_fb_motor_id,
    input  logic signed [31:0]          i_fb_position,
    input  logic [7:0]                  i_fb_error_code,
    input  logic signed [31:0]          i_target_position,
    input  logic signed [31:0]          i_target_speed,
    input  logic                        i_mode_entry_ok,
    input  logic                        i_send_ok,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_req_disable,
    output logic                        o_req_enter_mode,
    output logic                        o_req_send_target,
    output logic signed [31:0]          o_cmd_position,
    output logic [30:0]                 o_cmd_speed,
    output logic [2:0]                  o_run_state,
    output logic                        o_ready_res,
    output logic                        o_accepted,
    output logic                        o_has_feedback,
    output logic signed [31:0]          o_feedback_position,
    output logic [7:0]                  o_fault_err
);

    mbs_pkg::t_cfg    cfg;
    mbs_pkg::t_item   r_item;
    mbs_pkg::t_state  r_state;
    mbs_pkg::t_state  n_state;
    mbs_pkg::t_result r_result;
    mbs_pkg::t_result n_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             in_ready;

    mbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbs_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The held item moves on whenever the result register is free or being drained.
    assign advance  = r_in_valid && (!r_out_valid || !i_stall);
    assign in_ready = !r_in_valid || advance;
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid                 <= 1'b0;
            r_out_valid                <= 1'b0;
            r_state.phase              <= mbs_pkg::PH_IDLE;
            r_state.feedback_pending   <= 1'b0;
            r_state.err_pending        <= 1'b0;
            r_state.fault_value        <= 8'd0;
            r_state.last_fb_position   <= 32'sd0;
            r_state.seen_feedback      <= 1'b0;
            r_state.drive_enabled      <= 1'b0;
            r_state.fault_latch        <= 1'b0;
            r_state.hold_locked        <= 1'b0;
            r_state.goal_position      <= 32'sd0;
            r_state.goal_speed         <= mbs_pkg::DEFAULT_SPEED_RST;
            r_state.last_feedback_time <= 32'd0;
            r_state.last_send_time     <= 32'd0;
            r_state.mode_wait_start    <= 32'd0;
            r_state.mode_wait_length   <= mbs_pkg::AUTO_MODE_DELAY_RST;
            r_state.attempt_count      <= 4'd0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_item.cmd             <= i_cmd;
            r_item.now_ms          <= i_now_ms;
            r_item.fb_motor_id     <= i_fb_motor_id;
            r_item.fb_position     <= i_fb_position;
            r_item.fb_error_code   <= i_fb_error_code;
            r_item.target_position <= i_target_position;
            r_item.target_speed    <= i_target_speed;
            r_item.mode_entry_ok   <= i_mode_entry_ok;
            r_item.send_ok         <= i_send_ok;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_req_disable       = r_result.req_disable;
    assign o_req_enter_mode    = r_result.req_enter_mode;
    assign o_req_send_target   = r_result.req_send_target;
    assign o_cmd_position      = r_result.cmd_position;
    assign o_cmd_speed         = r_result.cmd_speed;
    assign o_run_state         = r_result.run_state;
    assign o_ready_res         = r_result.ready_res;
    assign o_accepted          = r_result.accepted;
    assign o_has_feedback      = r_result.has_feedback;
    assign o_feedback_position = r_result.feedback_position;
    assign o_fault_err         = r_result.fault_err;

endmodule

// ----- hw/rtl/mbs_checker.sv -----
module mbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_req_send_target,
    input logic signed [31:0] o_cmd_position,
    input logic [2:0]         o_run_state,
    input logic               o_ready_res,
    input logic               o_accepted,
    input logic               o_has_feedback
);

    // A stalled result beat holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_run_state) && $stable(o_cmd_position))
        else $error("stalled result beat changed");

    // Reset empties the result stage on the next edge.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready_res |-> o_run_state == mbs_pkg::RUN_READY && o_has_feedback)
        else $error("ready reported outside ready phase or without feedback");

    // Taking a target needs readiness, and nothing on that item can clear it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_ready_res)
        else $error("target accepted while not ready");

    // A send comes from the hold lock (ready or failed) or from a resend in ready.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req_send_target |->
            o_run_state == mbs_pkg::RUN_READY || o_run_state == mbs_pkg::RUN_FAILED)
        else $error("target send requested in a phase that cannot send");

endmodule

bind motor_bringup_supervisor mbs_checker u_mbs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_req_send_target (o_req_send_target),
    .o_cmd_position    (o_cmd_position),
    .o_run_state       (o_run_state),
    .o_ready_res       (o_ready_res),
    .o_accepted        (o_accepted),
    .o_has_feedback    (o_has_feedback)
);

// ----- sim/motor_bringup_supervisor_tb.sv -----
module motor_bringup_supervisor_tb;
    import mbs_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_cmd = CMD_TICK;
    logic [31:0]          i_now_ms = '0;
    logic [7:0]           i_fb_motor_id = '0;
    logic signed [31:0]   i_fb_position = '0;
    logic [7:0]           i_fb_error_code = '0;
    logic signed [31:0]   i_target_position = '0;
    logic signed [31:0]   i_target_speed = '0;
    logic                 i_mode_entry_ok = 1'b0;
    logic                 i_send_ok = 1'b0;

    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_req_disable;
    logic                 o_req_enter_mode;
    logic                 o_req_send_target;
    logic signed [31:0]   o_cmd_position;
    logic [30:0]          o_cmd_speed;
    logic [2:0]           o_run_state;
    logic                 o_ready_res;
    logic                 o_accepted;
    logic                 o_has_feedback;
    logic signed [31:0]   o_feedback_position;
    logic [7:0]           o_fault_err;

    motor_bringup_supervisor dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_cmd               (i_cmd),
        .i_now_ms            (i_now_ms),
        .i_fb_motor_id       (i_fb_motor_id),
        .i_fb_position       (i_fb_position),
        .i_fb_error_code     (i_fb_error_code),
        .i_target_position   (i_target_position),
        .i_target_speed      (i_target_speed),
        .i_mode_entry_ok     (i_mode_entry_ok),
        .i_send_ok           (i_send_ok),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_req_disable       (o_req_disable),
        .o_req_enter_mode    (o_req_enter_mode),
        .o_req_send_target   (o_req_send_target),
        .o_cmd_position      (o_cmd_position),
        .o_cmd_speed         (o_cmd_speed),
        .o_run_state         (o_run_state),
        .o_ready_res         (o_ready_res),
        .o_accepted          (o_accepted),
        .o_has_feedback      (o_has_feedback),
        .o_feedback_position (o_feedback_position),
        .o_fault_err         (o_fault_err)
    );

    class bringup_scoreboard;
        t_cfg        cfg;
        logic [2:0]  phase;
        bit          fb_pending;
        bit          err_pending;
        bit          seen;
        bit          enabled;
        bit          latched;
        bit          locked;
        logic [7:0]  fault_val;
        logic [31:0] fb_pos;
        logic [31:0] goal_pos;
        logic [30:0] goal_spd;
        logic [31:0] t_fb;
        logic [31:0] t_send;
        logic [31:0] wait_start;
        logic [15:0] wait_len;
        logic [3:0]  attempts;
        t_result     pending_results[$];
        int          errors;
        int          beat_count;

        function new();
            cfg.auto_mode_delay = AUTO_MODE_DELAY_RST;
            cfg.retry_delay     = RETRY_DELAY_RST;
            cfg.max_attempts    = MAX_ATTEMPTS_RST;
            cfg.resend_period   = RESEND_PERIOD_RST;
            cfg.stale_timeout   = STALE_TIMEOUT_RST;
            cfg.default_speed   = DEFAULT_SPEED_RST;
            cfg.own_motor_id    = OWN_MOTOR_ID_RST;
            errors = 0;
            beat_count = 0;
            restart_run();
        endfunction

        function void restart_run();
            phase = RUN_IDLE;
            fb_pending = 0;
            err_pending = 0;
            fault_val = '0;
            fb_pos = '0;
            seen = 0;
            enabled = 0;
            latched = 0;
            locked = 0;
            goal_pos = '0;
            goal_spd = cfg.default_speed;
            t_fb = '0;
            t_send = '0;
            wait_start = '0;
            wait_len = cfg.auto_mode_delay;
            attempts = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_AUTO_MODE_DELAY: cfg.auto_mode_delay = v[15:0];
                REG_RETRY_DELAY:     cfg.retry_delay = v[15:0];
                REG_MAX_ATTEMPTS:    cfg.max_attempts = v[3:0];
                REG_RESEND_PERIOD:   cfg.resend_period = v[15:0];
                REG_STALE_TIMEOUT:   cfg.stale_timeout = v[15:0];
                REG_DEFAULT_SPEED:   cfg.default_speed = v[30:0];
                REG_OWN_MOTOR_ID:    cfg.own_motor_id = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            logic [31:0] v;
            case (idx)
                REG_AUTO_MODE_DELAY: v = {16'd0, cfg.auto_mode_delay};
                REG_RETRY_DELAY:     v = {16'd0, cfg.retry_delay};
                REG_MAX_ATTEMPTS:    v = {28'd0, cfg.max_attempts};
                REG_RESEND_PERIOD:   v = {16'd0, cfg.resend_period};
                REG_STALE_TIMEOUT:   v = {16'd0, cfg.stale_timeout};
                REG_DEFAULT_SPEED:   v = {1'b0, cfg.default_speed};
                REG_OWN_MOTOR_ID:    v = {24'd0, cfg.own_motor_id};
                default:             v = '0;
            endcase
            return v;
        endfunction

        function bit ready_at(logic [31:0] now);
            logic [31:0] age;
            age = now - t_fb;
            return phase == RUN_READY && enabled && !latched && locked && seen &&
                   age <= {16'd0, cfg.stale_timeout};
        endfunction

        // Advances the supervision state by one accepted input beat and queues
        // the result beat it must produce.
        function void note_item(t_item it);
            t_result     r;
            logic [31:0] now;
            logic [31:0] age;
            bit          updated;
            bit          rq_dis;
            bit          rq_mode;
            bit          rq_send;
            bit          acc;
            now = it.now_ms;
            rq_dis = 0;
            rq_mode = 0;
            rq_send = 0;
            acc = 0;
            case (it.cmd)
                CMD_START: begin
                    restart_run();
                    rq_dis = 1;
                    t_fb = now;
                    t_send = now;
                    phase = RUN_WAIT_MODE;
                    wait_start = now;
                    wait_len = cfg.auto_mode_delay;
                end
                CMD_FEEDBACK: begin
                    if (it.fb_motor_id == cfg.own_motor_id) begin
                        fb_pos = it.fb_position;
                        fb_pending = 1;
                        if (it.fb_error_code >= FAULT_ERR_LO &&
                            it.fb_error_code <= FAULT_ERR_HI) begin
                            fault_val = it.fb_error_code;
                            err_pending = 1;
                        end
                    end
                end
                CMD_TARGET: begin
                    if (ready_at(now) && !it.target_speed[31]) begin
                        goal_pos = it.target_position;
                        goal_spd = it.target_speed[30:0];
                        acc = 1;
                    end
                end
                CMD_TICK: begin
                    updated = fb_pending;
                    fb_pending = 0;
                    if (err_pending) begin
                        // The fault wins: the pending frame is dropped unseen.
                        err_pending = 0;
                        latched = 1;
                        enabled = 0;
                        locked = 0;
                        phase = RUN_FAILED;
                        rq_dis = 1;
                    end else begin
                        age = now - wait_start;
                        if (phase == RUN_WAIT_MODE && age >= {16'd0, wait_len}) begin
                            attempts = attempts + 4'd1;
                            rq_mode = 1;
                            if (it.mode_entry_ok) begin
                                enabled = 1;
                                phase = RUN_WAIT_FB;
                                t_fb = now;
                                t_send = now;
                            end else if (attempts < cfg.max_attempts) begin
                                wait_start = now;
                                wait_len = cfg.retry_delay;
                            end else begin
                                enabled = 0;
                                locked = 0;
                                phase = RUN_FAILED;
                            end
                        end
                        if (updated) begin
                            seen = 1;
                            t_fb = now;
                            if (phase == RUN_WAIT_FB && enabled && !latched) begin
                                goal_pos = fb_pos;
                                goal_spd = cfg.default_speed;
                                rq_send = 1;
                                if (it.send_ok) begin
                                    locked = 1;
                                    t_send = now;
                                    phase = RUN_READY;
                                end else begin
                                    locked = 0;
                                    enabled = 0;
                                    phase = RUN_FAILED;
                                    rq_dis = 1;
                                end
                            end
                        end
                        age = now - t_send;
                        if (phase == RUN_READY && enabled && !latched && locked &&
                            age >= {16'd0, cfg.resend_period}) begin
                            t_send = now;
                            rq_send = 1;
                        end
                    end
                end
            endcase
            r = '0;
            r.req_disable       = rq_dis;
            r.req_enter_mode    = rq_mode;
            r.req_send_target   = rq_send;
            r.cmd_position      = goal_pos;
            r.cmd_speed         = goal_spd;
            r.run_state         = phase;
            r.ready_res         = ready_at(now);
            r.accepted          = acc;
            r.has_feedback      = seen;
            r.feedback_position = fb_pos;
            r.fault_err         = fault_val;
            pending_results.push_back(r);
        endfunction

        function void report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endfunction

        function void compare_field(string name, logic [31:0] g, logic [31:0] e);
            if (g !== e)
                report($sformatf("beat %0d %s: got %h, expected %h", beat_count, name, g, e));
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", beat_count));
                beat_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("req_disable", got.req_disable, want.req_disable);
            compare_field("req_enter_mode", got.req_enter_mode, want.req_enter_mode);
            compare_field("req_send_target", got.req_send_target, want.req_send_target);
            compare_field("cmd_position", got.cmd_position, want.cmd_position);
            compare_field("cmd_speed", got.cmd_speed, want.cmd_speed);
            compare_field("run_state", got.run_state, want.run_state);
            compare_field("ready_res", got.ready_res, want.ready_res);
            compare_field("accepted", got.accepted, want.accepted);
            compare_field("has_feedback", got.has_feedback, want.has_feedback);
            compare_field("feedback_position", got.feedback_position, want.feedback_position);
            compare_field("fault_err", got.fault_err, want.fault_err);
            beat_count++;
        endfunction
    endclass

    bringup_scoreboard sb;
    t_result           out_beat;
    int                sender_idle_pct = 0;
    int                stall_pct = 0;
    int                pressure_cycles = 0;
    bit                pressure_req = 1'b0;
    bit                pressure_done = 1'b0;
    logic [31:0]       now_cursor = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver side: one long hold-off once it is requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (pressure_req && !pressure_done) begin
            pressure_done   <= 1'b1;
            pressure_cycles <= 400;
            i_stall         <= 1'b1;
        end else if (pressure_cycles > 0) begin
            i_stall <= 1'b1;
            pressure_cycles <= pressure_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            out_beat.req_disable       = o_req_disable;
            out_beat.req_enter_mode    = o_req_enter_mode;
            out_beat.req_send_target   = o_req_send_target;
            out_beat.cmd_position      = o_cmd_position;
            out_beat.cmd_speed         = o_cmd_speed;
            out_beat.run_state         = o_run_state;
            out_beat.ready_res         = o_ready_res;
            out_beat.accepted          = o_accepted;
            out_beat.has_feedback      = o_has_feedback;
            out_beat.feedback_position = o_feedback_position;
            out_beat.fault_err         = o_fault_err;
            sb.check_beat(out_beat);
        end
    end

    task automatic drive(input t_item it);
        bit go;
        go = 0;
        while (!go) begin
            @(negedge i_clk);
            if ($urandom_range(99) < sender_idle_pct)
                i_valid <= 1'b0;
            else
                go = 1;
        end
        i_valid           <= 1'b1;
        i_cmd             <= it.cmd;
        i_now_ms          <= it.now_ms;
        i_fb_motor_id     <= it.fb_motor_id;
        i_fb_position     <= it.fb_position;
        i_fb_error_code   <= it.fb_error_code;
        i_target_position <= it.target_position;
        i_target_speed    <= it.target_speed;
        i_mode_entry_ok   <= it.mode_entry_ok;
        i_send_ok         <= it.send_ok;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
    endtask

    task automatic dir(input logic [1:0] cmd, input logic [31:0] now, input logic [7:0] id,
                       input logic [31:0] pos, input logic [7:0] err, input logic [31:0] tp,
                       input logic [31:0] ts, input bit mok, input bit sok);
        t_item it;
        it.cmd = cmd;
        it.now_ms = now;
        it.fb_motor_id = id;
        it.fb_position = pos;
        it.fb_error_code = err;
        it.target_position = tp;
        it.target_speed = ts;
        it.mode_entry_ok = mok;
        it.send_ok = sok;
        drive(it);
    endtask

    // Mostly well-formed bring-up traffic on a moving clock, with foreign frames,
    // faults, negative speeds and time jumps mixed in.
    function automatic t_item gen_item();
        t_item       it;
        int unsigned roll;
        int unsigned start_pct;
        roll = $urandom_range(99);
        if (roll < 70)
            now_cursor = now_cursor + $urandom_range(0, 20);
        else if (roll < 90)
            now_cursor = now_cursor + $urandom_range(0, 600);
        else if (roll < 98)
            now_cursor = now_cursor + $urandom_range(0, 70000);
        else
            now_cursor = $urandom();
        it.now_ms = now_cursor;
        it.fb_motor_id = ($urandom_range(99) < 80) ? sb.cfg.own_motor_id : 8'($urandom());
        it.fb_position = $urandom();
        it.fb_error_code = ($urandom_range(99) < 5) ? 8'($urandom_range(8, 14))
                                                    : 8'($urandom());
        it.target_position = $urandom();
        it.target_speed = ($urandom_range(99) < 80) ? {1'b0, 31'($urandom())} : $urandom();
        it.mode_entry_ok = ($urandom_range(99) < 75);
        it.send_ok = ($urandom_range(99) < 85);
        start_pct = (sb.phase == RUN_IDLE || sb.phase == RUN_FAILED) ? 25 : 2;
        roll = $urandom_range(99);
        if (roll < start_pct) begin
            it.cmd = CMD_START;
        end else begin
            roll = $urandom_range(99);
            if (roll < 45)
                it.cmd = CMD_TICK;
            else if (roll < 75)
                it.cmd = CMD_FEEDBACK;
            else
                it.cmd = CMD_TARGET;
        end
        return it;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = sb.reg_value(idx);
        if (prdata !== want)
            sb.report($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits for every expected beat to arrive, then for the pipeline latency.
    task automatic drain();
        int n;
        n = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0 && n < 50000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bring-up walk under the reset configuration.
        dir(CMD_TICK, 32'd0, 8'd1, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_TARGET, 32'd10, 8'd0, 32'd0, 8'd0, 32'h1234_0000, 32'h0001_0000, 0, 0);
        dir(CMD_FEEDBACK, 32'd20, 8'hFF, 32'h7FFF_FFFF, 8'h09, 32'd0, 32'd0, 0, 0);
        dir(CMD_START, 32'd1000, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'd1050, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_TICK, 32'd1100, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 1);
        dir(CMD_TICK, 32'd1599, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_TICK, 32'd1600, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_FEEDBACK, 32'd1600, 8'd1, 32'h7FFF_FFFF, 8'h00, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'd1601, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 1);
        dir(CMD_TARGET, 32'd1602, 8'd0, 32'd0, 8'd0, 32'h0000_1000, 32'hFFFF_FFFF, 0, 0);
        dir(CMD_TARGET, 32'd1603, 8'd0, 32'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        dir(CMD_TICK, 32'd1611, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 0);
        dir(CMD_FEEDBACK, 32'd1615, 8'd1, 32'd0, 8'h08, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'd1620, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_START, 32'hFFFF_FFF0, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'h0000_0054, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        dir(CMD_FEEDBACK, 32'h0000_0054, 8'd1, 32'h8000_0000, 8'h0F, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'h0000_0055, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 0);
        dir(CMD_START, 32'd5000, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'd5100, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 1);
        dir(CMD_TICK, 32'd5600, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 1);
        dir(CMD_TICK, 32'd6100, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 0, 1);
        dir(CMD_FEEDBACK, 32'd6150, 8'd1, 32'hFFFF_FFFF, 8'h0E, 32'd0, 32'd0, 0, 0);
        dir(CMD_TICK, 32'd6200, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1, 1);
        now_cursor = 32'd7000;

        for (int s = 0; s < 5; s++) begin
            drain();
            case (s)
                1: begin
                    // Low extremes, with a zero attempt limit.
                    reg_write(REG_AUTO_MODE_DELAY, 32'd0);
                    reg_write(REG_RETRY_DELAY, 32'd0);
                    reg_write(REG_MAX_ATTEMPTS, 32'd0);
                    reg_write(REG_RESEND_PERIOD, 32'd1);
                    reg_write(REG_STALE_TIMEOUT, 32'd0);
                    reg_write(REG_DEFAULT_SPEED, 32'd0);
                    reg_write(REG_OWN_MOTOR_ID, 32'd0);
                end
                2: begin
                    reg_write(REG_AUTO_MODE_DELAY, 32'd65535);
                    reg_write(REG_RETRY_DELAY, 32'd65535);
                    reg_write(REG_MAX_ATTEMPTS, 32'd15);
                    reg_write(REG_RESEND_PERIOD, 32'd65535);
                    reg_write(REG_STALE_TIMEOUT, 32'd65535);
                    reg_write(REG_DEFAULT_SPEED, 32'h7FFF_FFFF);
                    reg_write(REG_OWN_MOTOR_ID, 32'd255);
                end
                3, 4: begin
                    reg_write(REG_AUTO_MODE_DELAY, $urandom_range(0, 400));
                    reg_write(REG_RETRY_DELAY, $urandom_range(0, 800));
                    reg_write(REG_MAX_ATTEMPTS, $urandom_range(1, 15));
                    reg_write(REG_RESEND_PERIOD, $urandom_range(1, 50));
                    reg_write(REG_STALE_TIMEOUT, $urandom_range(0, 1000));
                    reg_write(REG_DEFAULT_SPEED, {1'b0, 31'($urandom())});
                    reg_write(REG_OWN_MOTOR_ID, $urandom_range(0, 255));
                end
                default: ;
            endcase
            for (int p = 0; p < 4; p++) begin
                sender_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 62 : 30) : 0;
                stall_pct = (p == 2) ? 62 : ((p == 3) ? 30 : 0);
                // Hold the result side off while items keep coming, so the
                // block backs up and stalls its input.
                if (s == 0 && p == 0)
                    pressure_req = 1'b1;
                repeat (70) drive(gen_item());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
